### rtl/ckc_pkg.sv
// Package for the C keyword counter: payload types, lexer modes, keyword table, char classes.
package ckc_pkg;

  localparam int MAX_WORD_DEF   = 100;
  localparam int COUNT_BITS_DEF = 32;
  localparam int KEYWORDS       = 31;
  localparam int KW_IDX_W       = $clog2(KEYWORDS);
  localparam int WORD_BYTES     = 8;
  localparam int WORD_W         = 8 * WORD_BYTES;
  localparam int HIT_W          = 32;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_EOF  = 1'b1
  } word_kind_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } ckc_in_t;

  typedef struct packed {
    logic [KW_IDX_W-1:0] keyword_index;
    logic [HIT_W-1:0]    hit_count;
    logic                any_found;
    logic                last;
  } ckc_out_t;

  typedef enum logic [2:0] {
    LX_START = 3'd0,
    LX_WORD  = 3'd1,
    LX_SLASH = 3'd2,
    LX_QUOTE = 3'd3,
    LX_QESC  = 3'd4,
    LX_LINE  = 3'd5,
    LX_BLOCK = 3'd6,
    LX_BSTAR = 3'd7
  } lexer_mode_t;

  typedef enum logic {
    ST_RUN    = 1'b0,
    ST_REPORT = 1'b1
  } ctl_state_t;

  // Keywords packed with the first character in the most significant used byte.
  localparam logic [WORD_W-1:0] KW_TEXT [KEYWORDS] = '{
    64'("auto"),     64'("break"),    64'("case"),     64'("char"),
    64'("continue"), 64'("default"),  64'("do"),       64'("double"),
    64'("else"),     64'("enum"),     64'("extern"),   64'("float"),
    64'("for"),      64'("goto"),     64'("if"),       64'("int"),
    64'("long"),     64'("register"), 64'("return"),   64'("short"),
    64'("signed"),   64'("sizeof"),   64'("static"),   64'("struct"),
    64'("switch"),   64'("typedef"),  64'("union"),    64'("unsigned"),
    64'("void"),     64'("volatile"), 64'("while")
  };

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_wordch(input logic [7:0] c);
    return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

### rtl/c_keyword_counter.sv
// C keyword counter: lexer step per accepted character, parallel keyword match, saturating counters.
// Flow: a character word updates lexer and counters at its accept edge; an end-of-input
//   word starts a report whose results are registered, one per cycle unless the output stalls.
// Throughput: one character word per cycle while not reporting; in_ready is low during a report,
//   which sends one result per nonzero counter (one empty result if none) and waits out stalls.
// Reset: rst clears lexer state, all counters and the output valid flag.
module c_keyword_counter #(
  parameter int MAX_WORD   = ckc_pkg::MAX_WORD_DEF,
  parameter int COUNT_BITS = ckc_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ckc_pkg::ckc_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output ckc_pkg::ckc_out_t out_data
);
  import ckc_pkg::*;

  localparam int LEN_W = $clog2(MAX_WORD);

  ctl_state_t  state, state_next;
  lexer_mode_t mode, mode_next;
  logic        quote_dbl, quote_dbl_next;
  logic [WORD_W-1:0] word, word_next;
  logic [LEN_W-1:0]  len, len_next;
  logic        starts_letter, starts_letter_next;
  logic        close_hit;

  logic [COUNT_BITS-1:0] counts [KEYWORDS];
  logic [KEYWORDS-1:0]   kw_match, nz, inc, clr;
  logic                  count_en;
  logic [KW_IDX_W-1:0]   sel_idx;
  logic [COUNT_BITS-1:0] sel_cnt;
  logic [HIT_W-1:0]      sel_hit;
  logic                  last_one, emit, acc;

  lexer_mode_t st_mode;
  logic        st_qd, st_begin;
  logic [7:0]  c;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state == ST_RUN);
  assign c        = in_data.char_code;

  always_comb begin
    st_mode  = LX_START;
    st_qd    = quote_dbl;
    st_begin = 1'b0;
    if (is_space(c)) begin
      st_mode = LX_START;
    end else if (is_letter(c) || c == CH_UNDERSCORE || c == CH_HASH) begin
      st_mode  = LX_WORD;
      st_begin = 1'b1;
    end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
      st_mode = LX_QUOTE;
      st_qd   = (c == CH_DQUOTE);
    end else if (c == CH_SLASH) begin
      st_mode = LX_SLASH;
    end
  end

  always_comb begin
    mode_next          = mode;
    quote_dbl_next     = quote_dbl;
    word_next          = word;
    len_next           = len;
    starts_letter_next = starts_letter;
    close_hit          = 1'b0;
    if (in_data.kind == KIND_EOF) begin
      close_hit          = (mode == LX_WORD);
      mode_next          = LX_START;
      quote_dbl_next     = 1'b0;
      word_next          = '0;
      len_next           = '0;
      starts_letter_next = 1'b0;
    end else begin
      case (mode)
        LX_WORD: begin
          if (is_wordch(c)) begin
            if (len == LEN_W'(MAX_WORD - 1)) begin
              mode_next          = LX_START;
              word_next          = '0;
              len_next           = '0;
              starts_letter_next = 1'b0;
            end else begin
              len_next = len + 1'b1;
              if (len < LEN_W'(WORD_BYTES)) begin
                word_next = {word[WORD_W-9:0], c};
              end
            end
          end else begin
            close_hit          = 1'b1;
            mode_next          = st_mode;
            quote_dbl_next     = st_qd;
            word_next          = st_begin ? {{(WORD_W-8){1'b0}}, c} : '0;
            len_next           = st_begin ? LEN_W'(1) : '0;
            starts_letter_next = st_begin && is_letter(c);
          end
        end
        LX_START, LX_SLASH: begin
          if (mode == LX_SLASH && c == CH_SLASH) begin
            mode_next = LX_LINE;
          end else if (mode == LX_SLASH && c == CH_STAR) begin
            mode_next = LX_BLOCK;
          end else begin
            mode_next      = st_mode;
            quote_dbl_next = st_qd;
            if (st_begin) begin
              word_next          = {{(WORD_W-8){1'b0}}, c};
              len_next           = LEN_W'(1);
              starts_letter_next = is_letter(c);
            end
          end
        end
        LX_QUOTE: begin
          if (c == CH_BACKSLASH) begin
            mode_next = LX_QESC;
          end else if (c == (quote_dbl ? CH_DQUOTE : CH_SQUOTE)) begin
            mode_next = LX_START;
          end
        end
        LX_QESC: begin
          mode_next = LX_QUOTE;
        end
        LX_LINE: begin
          if (c == CH_NEWLINE) begin
            mode_next = LX_START;
          end
        end
        LX_BLOCK: begin
          if (c == CH_STAR) begin
            mode_next = LX_BSTAR;
          end
        end
        LX_BSTAR: begin
          if (c == CH_SLASH) begin
            mode_next = LX_START;
          end else if (c != CH_STAR) begin
            mode_next = LX_BLOCK;
          end
        end
        default: begin
          mode_next = LX_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= LX_START;
      quote_dbl     <= 1'b0;
      word          <= '0;
      len           <= '0;
      starts_letter <= 1'b0;
    end else if (acc) begin
      mode          <= mode_next;
      quote_dbl     <= quote_dbl_next;
      word          <= word_next;
      len           <= len_next;
      starts_letter <= starts_letter_next;
    end
  end

  assign count_en = acc && close_hit && starts_letter && (len <= LEN_W'(WORD_BYTES));

  always_comb begin
    for (int k = 0; k < KEYWORDS; k++) begin
      kw_match[k] = (word == KW_TEXT[k]);
      nz[k]       = (counts[k] != '0);
    end
  end

  assign inc = kw_match & {KEYWORDS{count_en}};

  always_comb begin
    sel_idx = '0;
    for (int k = KEYWORDS - 1; k >= 0; k--) begin
      if (nz[k]) begin
        sel_idx = KW_IDX_W'(k);
      end
    end
  end

  assign sel_cnt  = counts[sel_idx];
  assign last_one = ((nz & (nz - 1'b1)) == '0);
  assign emit     = (state == ST_REPORT) && (!out_valid || out_ready);

  generate
    if (COUNT_BITS > HIT_W) begin : g_sat
      assign sel_hit = (|sel_cnt[COUNT_BITS-1:HIT_W]) ? '1 : sel_cnt[HIT_W-1:0];
    end else begin : g_ext
      assign sel_hit = HIT_W'(sel_cnt);
    end
  endgenerate

  always_comb begin
    for (int k = 0; k < KEYWORDS; k++) begin
      clr[k] = emit && nz[k] && (sel_idx == KW_IDX_W'(k));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < KEYWORDS; k++) begin
        counts[k] <= '0;
      end
    end else begin
      for (int k = 0; k < KEYWORDS; k++) begin
        if (clr[k]) begin
          counts[k] <= '0;
        end else if (inc[k] && !(&counts[k])) begin
          counts[k] <= counts[k] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (acc && in_data.kind == KIND_EOF) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (emit && last_one) begin
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.keyword_index <= (nz == '0) ? '0 : sel_idx;
      out_data.hit_count     <= (nz == '0) ? '0 : sel_hit;
      out_data.any_found     <= (nz != '0);
      out_data.last          <= last_one;
    end
  end

  a_empty_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.any_found |->
      out_data.last && out_data.hit_count == '0 && out_data.keyword_index == '0)
    else $error("empty report result malformed");

  a_eof_report: assert property (@(posedge clk) disable iff (rst)
    acc && in_data.kind == KIND_EOF |=> state == ST_REPORT && mode == LX_START)
    else $error("end of input did not start a report");

  a_counts_clear: assert property (@(posedge clk) disable iff (rst)
    $past(state) == ST_REPORT && state == ST_RUN |-> nz == '0)
    else $error("counters not cleared after report");

  a_word_idle: assert property (@(posedge clk) disable iff (rst)
    mode != LX_WORD |-> len == '0 && word == '0 && !starts_letter)
    else $error("word state left over outside a word");

endmodule

### verif/c_keyword_counter_test.sv
// Testbench for c_keyword_counter: directed and random C text, predicted keyword counts.
module c_keyword_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ckc_pkg::*;

  localparam int ID_LIMIT = MAX_WORD_DEF;
  localparam int ID_BYTES = 8;

  typedef enum {CC_SPACE, CC_ALPHA, CC_DIGIT, CC_UNDER, CC_OTHER} char_class_t;
  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY} rx_style_t;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  ckc_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ckc_out_t out_data;

  c_keyword_counter dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  string kw_names [KEYWORDS] = '{
    "auto", "break", "case", "char", "continue", "default", "do", "double",
    "else", "enum", "extern", "float", "for", "goto", "if", "int", "long",
    "register", "return", "short", "signed", "sizeof", "static", "struct",
    "switch", "typedef", "union", "unsigned", "void", "volatile", "while"
  };

  lexer_mode_t         lx_mode;
  bit                  q_double;
  logic [63:0]         id_text;
  int                  id_len;
  bit                  id_letter;
  logic [HIT_W-1:0]    kw_hits [KEYWORDS];

  ckc_out_t            expected_counts [$];
  logic [7:0]          src_q [$];

  int                  fail_count;
  int                  chars_sent;
  int                  eofs_sent;
  int                  results_total;
  int                  results_checked;
  int                  burst_left;
  bit                  tx_idle;
  rx_style_t           rx_mode;
  int                  hold_left;
  logic [15:0]         rx_pat;
  int                  rx_pos;

  // Prediction

  function automatic char_class_t classify(input logic [7:0] c);
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return CC_SPACE;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return CC_ALPHA;
    if (c >= "0" && c <= "9") return CC_DIGIT;
    if (c == CH_UNDERSCORE) return CC_UNDER;
    return CC_OTHER;
  endfunction

  function automatic void clear_predictor();
    lx_mode   = LX_START;
    q_double  = 1'b0;
    id_text   = '0;
    id_len    = 0;
    id_letter = 1'b0;
    for (int k = 0; k < KEYWORDS; k++) kw_hits[k] = '0;
  endfunction

  function automatic void close_ident();
    bit same;
    bit found;
    found = 1'b0;
    if (id_letter && id_len <= ID_BYTES) begin
      for (int k = 0; k < KEYWORDS; k++) begin
        if (!found) begin
          same = (kw_names[k].len() == id_len);
          for (int i = 0; i < kw_names[k].len(); i++) begin
            if (i >= id_len || id_text[8*i +: 8] != kw_names[k][i]) same = 1'b0;
          end
          if (same) begin
            found = 1'b1;
            if (kw_hits[k] != '1) kw_hits[k] = kw_hits[k] + 1'b1;
          end
        end
      end
    end
    id_text   = '0;
    id_len    = 0;
    id_letter = 1'b0;
    lx_mode   = LX_START;
  endfunction

  function automatic void grow_ident(input logic [7:0] c);
    if (id_len < ID_BYTES) id_text[8*id_len +: 8] = c;
    id_len++;
    if (id_len >= ID_LIMIT) close_ident();
  endfunction

  function automatic void begin_token(input logic [7:0] c);
    char_class_t cls;
    cls = classify(c);
    if (cls == CC_SPACE) return;
    if (cls == CC_ALPHA || c == CH_UNDERSCORE || c == CH_HASH) begin
      id_text   = '0;
      id_len    = 0;
      id_letter = (cls == CC_ALPHA);
      lx_mode   = LX_WORD;
      grow_ident(c);
    end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
      q_double = (c == CH_DQUOTE);
      lx_mode  = LX_QUOTE;
    end else if (c == CH_SLASH) begin
      lx_mode = LX_SLASH;
    end
  endfunction

  function automatic void lex_char(input logic [7:0] c);
    char_class_t cls;
    cls = classify(c);
    case (lx_mode)
      LX_START: begin
        begin_token(c);
      end
      LX_WORD: begin
        if (cls == CC_ALPHA || cls == CC_DIGIT || cls == CC_UNDER) begin
          grow_ident(c);
        end else begin
          close_ident();
          begin_token(c);
        end
      end
      LX_SLASH: begin
        if (c == CH_SLASH) lx_mode = LX_LINE;
        else if (c == CH_STAR) lx_mode = LX_BLOCK;
        else begin
          lx_mode = LX_START;
          begin_token(c);
        end
      end
      LX_QUOTE: begin
        if (c == CH_BACKSLASH) lx_mode = LX_QESC;
        else if (c == (q_double ? CH_DQUOTE : CH_SQUOTE)) lx_mode = LX_START;
      end
      LX_QESC: begin
        lx_mode = LX_QUOTE;
      end
      LX_LINE: begin
        if (c == CH_NEWLINE) lx_mode = LX_START;
      end
      LX_BLOCK: begin
        if (c == CH_STAR) lx_mode = LX_BSTAR;
      end
      default: begin
        if (c == CH_SLASH) lx_mode = LX_START;
        else if (c != CH_STAR) lx_mode = LX_BLOCK;
      end
    endcase
  endfunction

  function automatic void report_counts();
    ckc_out_t r;
    int last_k;
    if (lx_mode == LX_WORD) close_ident();
    last_k = -1;
    for (int k = 0; k < KEYWORDS; k++) if (kw_hits[k] != '0) last_k = k;
    if (last_k < 0) begin
      r      = '0;
      r.last = 1'b1;
      expected_counts.push_back(r);
      results_total++;
    end else begin
      for (int k = 0; k < KEYWORDS; k++) begin
        if (kw_hits[k] != '0) begin
          r.keyword_index = KW_IDX_W'(k);
          r.hit_count     = kw_hits[k];
          r.any_found     = 1'b1;
          r.last          = (k == last_k);
          expected_counts.push_back(r);
          results_total++;
        end
      end
    end
    clear_predictor();
  endfunction

  // Clock, reset, limit

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver

  initial begin
    out_ready = 1'b0;
    rx_pat    = '1;
    rx_pos    = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (rx_pos == 0) begin
          case (rx_mode)
            RX_FREE:  rx_pat = '1;
            RX_LIGHT: rx_pat = 16'($urandom | $urandom);
            default:  rx_pat = 16'($urandom & $urandom);
          endcase
        end
        out_ready <= rx_pat[rx_pos];
        rx_pos = (rx_pos + 1) % 16;
      end
    end
  end

  // Checker

  ckc_out_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (expected_counts.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result idx %0d count %0d found %0b last %0b", $time,
                 out_data.keyword_index, out_data.hit_count, out_data.any_found,
                 out_data.last);
      end else begin
        want = expected_counts.pop_front();
        if (out_data.keyword_index !== want.keyword_index) begin
          fail_count++;
          $display("%0t: keyword_index expected %0d, got %0d", $time,
                   want.keyword_index, out_data.keyword_index);
        end
        if (out_data.hit_count !== want.hit_count) begin
          fail_count++;
          $display("%0t: hit_count expected %0d, got %0d", $time,
                   want.hit_count, out_data.hit_count);
        end
        if (out_data.any_found !== want.any_found) begin
          fail_count++;
          $display("%0t: any_found expected %0b, got %0b", $time,
                   want.any_found, out_data.any_found);
        end
        if (out_data.last !== want.last) begin
          fail_count++;
          $display("%0t: last expected %0b, got %0b", $time, want.last, out_data.last);
        end
      end
    end
  end

  // Sender

  task automatic send_word(input word_kind_t k, input logic [7:0] c);
    ckc_in_t w;
    int g;
    if (tx_idle && burst_left == 0) begin
      g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      repeat (g) @(negedge clk) in_valid <= 1'b0;
    end
    if (burst_left > 0) burst_left--;
    w.kind      = k;
    w.char_code = c;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (k == KIND_EOF) begin
      eofs_sent++;
      report_counts();
    end else begin
      chars_sent++;
      lex_char(c);
    end
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
  endtask

  task automatic send_source();
    while (src_q.size() != 0) send_word(KIND_CHAR, src_q.pop_front());
  endtask

  task automatic send_text(input string s);
    push_text(s);
    send_source();
  endtask

  task automatic send_eof();
    send_word(KIND_EOF, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_all_counts();
    @(negedge clk) in_valid <= 1'b0;
    burst_left = 0;
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  // Random source generation

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'("a" + $urandom_range(0, 25));
    if ($urandom_range(0, 3) == 0) c = 8'("A" + $urandom_range(0, 25));
    return c;
  endfunction

  task automatic push_ident();
    int n;
    int pick;
    case ($urandom_range(0, 5))
      0:       src_q.push_back(CH_UNDERSCORE);
      1:       src_q.push_back(CH_HASH);
      default: src_q.push_back(rand_letter());
    endcase
    n = $urandom_range(0, 10);
    repeat (n) begin
      pick = $urandom_range(0, 5);
      if (pick == 0) src_q.push_back(CH_UNDERSCORE);
      else if (pick == 1) src_q.push_back(8'("0" + $urandom_range(0, 9)));
      else src_q.push_back(rand_letter());
    end
  endtask

  task automatic push_space();
    case ($urandom_range(0, 8))
      0, 1, 2: src_q.push_back(CH_SPACE);
      3:       src_q.push_back(CH_TAB);
      4:       src_q.push_back(CH_NEWLINE);
      5:       src_q.push_back(CH_CR);
      6:       push_text($urandom_range(0, 1) ? "\v" : "\f");
      default: ;
    endcase
  endtask

  task automatic push_token();
    string punct;
    logic [7:0] q;
    int n;
    punct = ";(){}[]=+-<>,.&|!%^~?:*";
    case ($urandom_range(0, 13))
      0, 1, 2, 3: push_text(kw_names[$urandom_range(0, KEYWORDS - 1)]);
      4: push_ident();
      5: begin
        push_text(kw_names[$urandom_range(0, KEYWORDS - 1)]);
        push_ident();
      end
      6: repeat ($urandom_range(1, 4)) src_q.push_back(8'("0" + $urandom_range(0, 9)));
      7: src_q.push_back(punct[$urandom_range(0, punct.len() - 1)]);
      8: begin
        push_text("//");
        push_text(kw_names[$urandom_range(0, KEYWORDS - 1)]);
        if ($urandom_range(0, 3) != 0) src_q.push_back(CH_NEWLINE);
      end
      9: begin
        push_text("/*");
        n = $urandom_range(0, 6);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0: src_q.push_back(CH_STAR);
            1: src_q.push_back(CH_SLASH);
            2: push_text(kw_names[$urandom_range(0, KEYWORDS - 1)]);
            3: src_q.push_back(CH_SPACE);
            default: src_q.push_back(rand_letter());
          endcase
        end
        if ($urandom_range(0, 5) != 0) push_text("*/");
      end
      10: begin
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        src_q.push_back(q);
        n = $urandom_range(0, 5);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0: begin
              src_q.push_back(CH_BACKSLASH);
              case ($urandom_range(0, 3))
                0: src_q.push_back(q);
                1: src_q.push_back(CH_BACKSLASH);
                default: src_q.push_back(8'($urandom_range(0, 255)));
              endcase
            end
            1: src_q.push_back(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
            2: src_q.push_back(CH_SPACE);
            default: push_text(kw_names[$urandom_range(0, KEYWORDS - 1)]);
          endcase
        end
        if ($urandom_range(0, 7) != 0) src_q.push_back(q);
      end
      11: begin
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(ID_LIMIT - 5, ID_LIMIT + 5)) src_q.push_back(rand_letter());
        else
          src_q.push_back(CH_SLASH);
      end
      default: repeat ($urandom_range(1, 3)) src_q.push_back(8'($urandom_range(0, 255)));
    endcase
    push_space();
  endtask

  // Tests

  task automatic test_no_keywords();
    send_eof();
    send_text("x9 _if #define Int WHILE; 42");
    send_eof();
  endtask

  task automatic test_every_keyword();
    for (int k = 0; k < KEYWORDS; k++) begin
      push_text(kw_names[k]);
      push_space();
      src_q.push_back(CH_SPACE);
    end
    push_text("while\twhile");
    send_source();
    send_word(KIND_EOF, 8'h00);
  endtask

  task automatic test_comments();
    send_text("/* int */ for /*/ char */ do // long\nif /**/ else /***/ goto ");
    send_text("a/b/case x//y\n*/ break");
    send_word(KIND_EOF, 8'hFF);
  endtask

  task automatic test_literals();
    send_text("'i' \"int \\\" long\" short '\\'' \"a\\\\\" enum 'x\"for' sizeof");
    send_eof();
  endtask

  task automatic test_word_rules();
    send_text("_int #int int2 Int INT intx x_int 9int unsigned unsigneds ");
    send_text("if");
    send_word(KIND_CHAR, 8'h80);
    send_text("do");
    send_word(KIND_CHAR, 8'hFF);
    send_text("for");
    send_word(KIND_CHAR, 8'h7F);
    send_text("void");
    send_word(KIND_CHAR, 8'h00);
    send_eof();
  endtask

  task automatic test_long_word();
    repeat (ID_LIMIT) src_q.push_back("x");
    push_text("int ");
    repeat (ID_LIMIT - 1) src_q.push_back("y");
    push_text("int ");
    repeat (ID_LIMIT - 2) src_q.push_back("z");
    push_text("if");
    send_source();
    send_eof();
  endtask

  task automatic test_eof_edges();
    send_text("volatile");
    send_eof();
    send_text("\"struct");
    send_eof();
    send_text("struct/* auto");
    send_eof();
    send_text("auto// case");
    send_eof();
    send_text("case /");
    send_eof();
    send_text("char '\\");
    send_eof();
  endtask

  task automatic test_backpressure();
    rx_mode   = RX_FREE;
    tx_idle   = 1'b0;
    hold_left = 400;
    send_text("int a; while (a) { int b; return b; }");
    send_eof();
    send_text("char c; static long d; typedef union u;");
    send_eof();
    send_text("switch default");
    send_eof();
  endtask

  task automatic test_pause();
    tx_idle = 1'b1;
    rx_mode = RX_LIGHT;
    send_text("extern float f; register double g;");
    send_eof();
    wait_all_counts();
    send_text("continue; signed short s;");
    send_eof();
    wait_all_counts();
  endtask

  task automatic test_random();
    int base_chars;
    base_chars = chars_sent;
    while (chars_sent - base_chars < 100) begin
      rx_mode = rx_style_t'($urandom_range(0, 2));
      tx_idle = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(3, 30)) push_token();
      send_source();
      send_eof();
      if ($urandom_range(0, 5) == 0) wait_all_counts();
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    fail_count = 0;
    chars_sent = 0;
    eofs_sent  = 0;
    results_total   = 0;
    results_checked = 0;
    burst_left = 0;
    tx_idle    = 1'b1;
    rx_mode    = RX_LIGHT;
    hold_left  = 0;
    clear_predictor();
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_no_keywords();
    test_every_keyword();
    tx_idle = 1'b0;
    rx_mode = RX_FREE;
    test_comments();
    rx_mode = RX_HEAVY;
    test_literals();
    tx_idle = 1'b1;
    test_word_rules();
    rx_mode = RX_LIGHT;
    test_long_word();
    test_eof_edges();
    test_backpressure();
    test_pause();
    test_random();

    wait_all_counts();
    repeat (20) @(posedge clk);
    $display("Sent %0d characters and %0d end-of-input words; checked %0d count reports.",
             chars_sent, eofs_sent, results_checked);
    $display("Covered comments, literals, long words, high bytes, stalls and back-pressure.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
